// ===== rtl/core/bhpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

    localparam int KEY_W        = 32;
    localparam int CAPACITY_DEF = 64;
    localparam int COUNT_OUT_W  = 7;
    localparam int STATUS_W     = 2;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int OUT_DATA_W   = 72;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_ORDER = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/core/bhpq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/bhpq_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bhpq_cmp
    import bhpq_pkg::*;
(
    input  wire  signed [KEY_W-1:0] a,
    input  wire  signed [KEY_W-1:0] b,
    input  wire                     order_is_min,
    output logic                    above
);

    // a belongs strictly above b in the selected order
    always_comb
    begin
        if (order_is_min)
        begin
            above = (a < b);
        end
        else
        begin
            above = (b < a);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/binary_heap_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Insert: the key climbs by parent read and compare (S_UP_RD, S_UP_CMP) until it stops
// below its parent or at the root. Delete: the last entry is read (S_DN_LAST, S_DN_LOAD),
// then sinks by left read, right read and compare (S_DN_RDL, S_DN_RDR, S_DN_CMP) per level.
// Last-key delete and full or empty refusals go straight to S_FINISH. One item in flight; the
// next is taken the cycle after the result loads, while the result waits in the output register.
// Reset (rst_n, async, low) empties the heap and selects max order; RAM is not cleared.
module binary_heap_priority_queue
    import bhpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    // APB configuration
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [CFG_ADDR_W-1:0]   paddr,
    input  wire  [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]   prdata,
    output logic                    pready,
    // input stream
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire  [KEY_W-1:0]        s_axis_tdata,   // [31:0] key_value
    input  wire                     s_axis_tuser,   // [0] action
    // result stream
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,   // [31:0] removed_value, [63:32] top_value,
                                                    // [70:64] entry_count, [71] zero
    output logic [STATUS_W-1:0]     m_axis_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int WI_W  = IDX_W + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_LOAD,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_FINISH
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [IDX_W-1:0]       pos_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] best_val_reg;
    logic                   best_left_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [KEY_W-1:0]       removed_reg;
    logic [KEY_W-1:0]       top_reg;
    logic                   order_reg;

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [KEY_W-1:0]       out_removed_reg;
    logic [KEY_W-1:0]       out_top_reg;
    logic [COUNT_OUT_W-1:0] out_cnt_reg;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [KEY_W-1:0]       ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [KEY_W-1:0]       ram_rdata;

    logic signed [KEY_W-1:0] cmp_a;
    logic signed [KEY_W-1:0] cmp_b;
    logic                   cmp_above;

    logic [WI_W-1:0]        pos_w;
    logic [WI_W-1:0]        lc_w;
    logic [WI_W-1:0]        rc_w;
    logic [WI_W-1:0]        cnt_w;
    logic [IDX_W-1:0]       parent;
    logic                   lc_ok;
    logic                   rc_ok;
    logic                   right_wins;
    logic                   child_moves;
    logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;
    logic                   cfg_write;
    logic                   out_free;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ORDER);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ORDER)
        begin
            prdata = {{(CFG_DATA_W-1){1'b0}}, order_reg};
        end
    end

    // ------------------------------------------------------------------
    // index arithmetic
    // ------------------------------------------------------------------
    assign pos_w  = {2'b00, pos_reg};
    assign lc_w   = {pos_w[WI_W-2:0], 1'b1};
    assign rc_w   = lc_w + WI_W'(1);
    assign cnt_w  = {{(WI_W-CNT_W){1'b0}}, cnt_reg};
    assign parent = (pos_reg - IDX_W'(1)) >> 1;
    assign lc_ok  = (lc_w < cnt_w);
    assign rc_ok  = (rc_w < cnt_w);

    // ------------------------------------------------------------------
    // shared comparator
    // ------------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = key_reg;
                cmp_b = ram_rdata;
            end
            S_DN_RDR:
            begin
                cmp_a = ram_rdata;
                cmp_b = key_reg;
            end
            S_DN_CMP:
            begin
                cmp_a = ram_rdata;
                cmp_b = best_val_reg;
            end
            default:
            begin
                cmp_a = key_reg;
                cmp_b = ram_rdata;
            end
        endcase
    end

    bhpq_cmp u_cmp (
        .a            (cmp_a),
        .b            (cmp_b),
        .order_is_min (order_reg),
        .above        (cmp_above)
    );

    assign right_wins  = rc_ok && cmp_above;
    assign child_moves = right_wins || best_left_reg;

    // ------------------------------------------------------------------
    // heap RAM control; the moving key rides in key_reg, the hole at pos_reg
    // ------------------------------------------------------------------
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = key_reg;
        ram_raddr = '0;
        case (state_reg)
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_raddr = parent;
                end
            end
            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (cmp_above)
                begin
                    ram_wdata = ram_rdata;
                end
            end
            S_DN_LAST:
            begin
                ram_raddr = cnt_reg[IDX_W-1:0];
            end
            S_DN_RDL:
            begin
                if (!lc_ok)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_raddr = lc_w[IDX_W-1:0];
                end
            end
            S_DN_RDR:
            begin
                ram_raddr = rc_w[IDX_W-1:0];
            end
            S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (right_wins)
                begin
                    ram_wdata = ram_rdata;
                end
                else if (best_left_reg)
                begin
                    ram_wdata = best_val_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    bhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cnt_ext       = {{COUNT_OUT_W{1'b0}}, cnt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            pos_reg         <= '0;
            key_reg         <= '0;
            best_val_reg    <= '0;
            best_left_reg   <= 1'b0;
            status_reg      <= ST_DONE;
            removed_reg     <= '0;
            top_reg         <= '0;
            order_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_DONE;
            out_removed_reg <= '0;
            out_top_reg     <= '0;
            out_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                order_reg <= pwdata[0];
            end

            // mirror of the root entry
            if (ram_we && (ram_waddr == '0))
            begin
                top_reg <= ram_wdata;
            end

            // S_FINISH reloads the output register itself
            if (out_valid_reg && m_axis_tready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        status_reg  <= ST_DONE;
                        removed_reg <= '0;
                        if (s_axis_tuser == ACT_INSERT)
                        begin
                            if (cnt_reg == CNT_W'(CAPACITY))
                            begin
                                status_reg <= ST_FULL;
                                state_reg  <= S_FINISH;
                            end
                            else
                            begin
                                key_reg   <= s_axis_tdata;
                                pos_reg   <= cnt_reg[IDX_W-1:0];
                                cnt_reg   <= cnt_reg + CNT_W'(1);
                                state_reg <= S_UP_RD;
                            end
                        end
                        else
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_reg <= ST_EMPTY;
                                state_reg  <= S_FINISH;
                            end
                            else
                            begin
                                removed_reg <= top_reg;
                                cnt_reg     <= cnt_reg - CNT_W'(1);
                                if (cnt_reg == CNT_W'(1))
                                begin
                                    state_reg <= S_FINISH;
                                end
                                else
                                begin
                                    state_reg <= S_DN_LAST;
                                end
                            end
                        end
                    end
                end
                S_UP_RD:
                begin
                    if (pos_reg == '0)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_UP_CMP;
                    end
                end
                S_UP_CMP:
                begin
                    if (cmp_above)
                    begin
                        pos_reg   <= parent;
                        state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_DN_LAST:
                begin
                    state_reg <= S_DN_LOAD;
                end
                S_DN_LOAD:
                begin
                    key_reg   <= ram_rdata;
                    pos_reg   <= '0;
                    state_reg <= S_DN_RDL;
                end
                S_DN_RDL:
                begin
                    if (!lc_ok)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_DN_RDR;
                    end
                end
                S_DN_RDR:
                begin
                    if (cmp_above)
                    begin
                        best_val_reg  <= ram_rdata;
                        best_left_reg <= 1'b1;
                    end
                    else
                    begin
                        best_val_reg  <= key_reg;
                        best_left_reg <= 1'b0;
                    end
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if (child_moves)
                    begin
                        pos_reg   <= right_wins ? rc_w[IDX_W-1:0] : lc_w[IDX_W-1:0];
                        state_reg <= S_DN_RDL;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_status_reg  <= status_reg;
                        out_removed_reg <= removed_reg;
                        out_top_reg     <= (cnt_reg != '0) ? top_reg : '0;
                        out_cnt_reg     <= cnt_ext[COUNT_OUT_W-1:0];
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {1'b0, out_cnt_reg, out_top_reg, out_removed_reg};

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in work");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
            (m_axis_tdata[70:64] == '0) && (m_axis_tdata[63:32] == '0))
        else $error("empty refusal with keys held");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({2'b00, ram_waddr} < cnt_w))
        else $error("heap write beyond held entries");
`endif

endmodule

`default_nettype wire
